// ----- rtl/swms_pkg.sv -----
// ----------------------------------------------------------------------------
// swms_pkg: shared types and constants for the sorted window minimum spread
// Widths of samples, running sums and scores, config register indexes, the
// control state encoding and the divider status word.
// ----------------------------------------------------------------------------
package swms_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int WINDOW_MAX = 256;
    localparam int ADDR_W     = $clog2(WINDOW_MAX);
    localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W      = SAMPLE_W + ADDR_W + 1;
    localparam int SQ_W       = 2 * SAMPLE_W;
    localparam int SQSUM_W    = 2 * SAMPLE_W - 2 + ADDR_W + 1;
    localparam int MAG_W      = SUM_W - 1;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int KEY_W      = 64;
    localparam int CRIT_W     = 63;
    localparam int DIV_W      = KEY_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LEN_W;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_MODE = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SQ,
        ST_MUL,
        ST_CMP,
        ST_FIN,
        ST_SQR,
        ST_DIVK,
        ST_DIVC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } div_stat_t;

endpackage

// ----- rtl/sorted_window_min_spread.sv -----
// ----------------------------------------------------------------------------
// sorted_window_min_spread: minimum spread window over a sorted stream
// Scores every window of window_len contiguous samples by range or by sum of
// squared deviations and reports the best one when the set closes.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write window_len (index 0) or variance_mode (index 1) on
//   the cfg channel while the block is idle; each write drops the current set.
//   Input: one sample word per accepted in_valid/!in_stall; last_sample closes
//   the set. Each sample goes through accept, delay memory read, square
//   update, multiply and compare, and a new word is taken after the compare.
//   Output: one word per set, centre/criterion/status, held in an output
//   register. Range mode presents it through the finish, square and output
//   states after the last sample; variance mode runs two 64-step divisions by
//   the window length. While out_stall is high the result holds and the block
//   keeps taking samples of the next set until it needs the output register again.
//   Reset: window_len = 1, range mode, empty set. The delay memory needs no
//   clearing: only entries written in the current set are ever used.
// ----------------------------------------------------------------------------
module sorted_window_min_spread (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [swms_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [swms_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [swms_pkg::SAMPLE_W-1:0]   sample,
    input  logic                                   last_sample,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [swms_pkg::SAMPLE_W-1:0]   centre,
    output logic [swms_pkg::CRIT_W-1:0]            criterion,
    output logic                                   status
);

    localparam int SW = swms_pkg::SAMPLE_W;
    localparam int AW = swms_pkg::ADDR_W;
    localparam int LW = swms_pkg::LEN_W;
    localparam int UW = swms_pkg::SUM_W;
    localparam int QW = swms_pkg::SQ_W;
    localparam int SQW = swms_pkg::SQSUM_W;
    localparam int MW = swms_pkg::MAG_W;
    localparam int DW = swms_pkg::DIFF_W;
    localparam int KW = swms_pkg::KEY_W;
    localparam int CW = swms_pkg::CRIT_W;

    swms_pkg::state_t state_reg, state_next;

    // configuration
    logic [LW-1:0]          win_len_reg;
    logic                   var_mode_reg;
    logic [LW-1:0]          len_eff;

    // stream state
    logic [AW-1:0]          pos_reg;
    logic [LW-1:0]          seen_reg;
    logic signed [UW-1:0]   s1_reg;
    logic [SQW-1:0]         s2_reg;
    logic [KW-1:0]          best_key_reg;
    logic signed [UW-1:0]   best_csum_reg;
    logic                   have_best_reg;

    // per-sample working registers
    logic signed [SW-1:0]   v_reg;
    logic                   last_reg;
    logic                   full_reg;
    logic signed [SW-1:0]   first_reg;
    logic [QW-1:0]          sqv_reg;
    logic [QW-1:0]          sqo_reg;
    logic signed [DW-1:0]   diff_reg;
    logic signed [DW-1:0]   csum_s_reg;
    logic [MW-1:0]          m_reg;
    logic [KW-1:0]          p1_reg;
    logic [KW-1:0]          p2_reg;

    // result staging and output register
    logic signed [SW-1:0]   res_centre_reg;
    logic [CW-1:0]          res_crit_reg;
    logic                   res_status_reg;
    logic                   out_valid_reg;
    logic signed [SW-1:0]   out_centre_reg;
    logic [CW-1:0]          out_crit_reg;
    logic                   out_status_reg;

    // handshake and control
    logic                   in_acc;
    logic                   cfg_acc;
    logic                   out_load;
    logic                   div_start;
    logic                   stream_clear;

    // memory
    logic [AW-1:0]          rd_addr_old;
    logic [AW-1:0]          rd_addr_first;
    logic signed [SW-1:0]   rd_old;
    logic signed [SW-1:0]   rd_first;

    // combinational datapath
    logic signed [SW-1:0]   old_sel;
    logic signed [SW-1:0]   first_sel;
    logic signed [QW-1:0]   sqv_w;
    logic signed [QW-1:0]   sqo_w;
    logic [KW-1:0]          p1_w;
    logic [KW-1:0]          mm_w;
    logic [KW-1:0]          crit_sh;
    logic [KW-1:0]          key_w;
    logic signed [UW-1:0]   csum_w;
    logic                   win_full;
    logic [KW-1:0]          dsx;
    logic [KW-1:0]          dmag;
    logic                   csum_neg;
    logic signed [UW-1:0]   csum_mag;
    logic [swms_pkg::DIV_W-1:0] div_dividend;
    logic [swms_pkg::DIV_W-1:0] div_q;
    swms_pkg::div_stat_t    div_stat;
    logic [SW-1:0]          cq;

    assign len_eff = (win_len_reg == '0) ? LW'(1) :
                     (win_len_reg > LW'(swms_pkg::WINDOW_MAX)) ? LW'(swms_pkg::WINDOW_MAX) :
                     win_len_reg;

    assign in_acc  = in_valid && !in_stall;
    assign cfg_acc = cfg_valid && cfg_ready;
    assign win_full = seen_reg >= len_eff;

    // oldest sample leaving the window, and the first sample of the new one
    assign rd_addr_old   = pos_reg - len_eff[AW-1:0];
    assign rd_addr_first = rd_addr_old + 1'b1;

    swms_ram u_ram (
        .clk       (clk),
        .wr_en     (in_acc),
        .wr_addr   (pos_reg),
        .wr_data   (sample),
        .rd_addr_a (rd_addr_old),
        .rd_addr_b (rd_addr_first),
        .rd_data_a (rd_old),
        .rd_data_b (rd_first)
    );

    // a one-sample window starts at the sample just written
    assign old_sel   = full_reg ? rd_old : '0;
    assign first_sel = (len_eff == LW'(1)) ? v_reg : rd_first;
    assign sqv_w     = v_reg * v_reg;
    assign sqo_w     = old_sel * old_sel;
    assign p1_w      = len_eff * s2_reg;
    assign mm_w      = m_reg * m_reg;
    assign crit_sh   = mm_w >> 2;

    assign key_w  = var_mode_reg ? (p1_reg - p2_reg) :
                    {~diff_reg[DW-1], {(KW-DW){diff_reg[DW-1]}}, diff_reg[DW-2:0]};
    assign csum_w = var_mode_reg ? s1_reg :
                    {{(UW-DW){csum_s_reg[DW-1]}}, csum_s_reg};

    // undo the sign bias of the range key
    assign dsx  = best_key_reg ^ {1'b1, {(KW-1){1'b0}}};
    assign dmag = dsx[KW-1] ? (-dsx) : dsx;

    assign csum_neg     = best_csum_reg[UW-1];
    assign csum_mag     = csum_neg ? (-best_csum_reg) : best_csum_reg;
    assign div_dividend = (state_reg == swms_pkg::ST_FIN) ? best_key_reg :
                          swms_pkg::DIV_W'(unsigned'(csum_mag));
    assign cq = div_q[SW-1:0] + SW'(csum_neg && div_stat.rem_nz);

    swms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (len_eff),
        .quotient (div_q),
        .stat     (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swms_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cfg_ready    = 1'b0;
        in_stall     = 1'b1;
        out_load     = 1'b0;
        div_start    = 1'b0;
        stream_clear = 1'b0;
        case (state_reg)
            swms_pkg::ST_IDLE:
            begin
                cfg_ready = 1'b1;
                in_stall  = cfg_valid;
                if (in_valid && !cfg_valid)
                begin
                    state_next = swms_pkg::ST_READ;
                end
            end
            swms_pkg::ST_READ: state_next = swms_pkg::ST_SQ;
            swms_pkg::ST_SQ:   state_next = swms_pkg::ST_MUL;
            swms_pkg::ST_MUL:  state_next = swms_pkg::ST_CMP;
            swms_pkg::ST_CMP:
            begin
                state_next = last_reg ? swms_pkg::ST_FIN : swms_pkg::ST_IDLE;
            end
            swms_pkg::ST_FIN:
            begin
                if (!win_full || !have_best_reg)
                begin
                    state_next = swms_pkg::ST_OUT;
                end
                else if (var_mode_reg)
                begin
                    div_start  = 1'b1;
                    state_next = swms_pkg::ST_DIVK;
                end
                else
                begin
                    state_next = swms_pkg::ST_SQR;
                end
            end
            swms_pkg::ST_SQR:  state_next = swms_pkg::ST_OUT;
            swms_pkg::ST_DIVK:
            begin
                if (div_stat.done)
                begin
                    div_start  = 1'b1;
                    state_next = swms_pkg::ST_DIVC;
                end
            end
            swms_pkg::ST_DIVC:
            begin
                if (div_stat.done)
                begin
                    state_next = swms_pkg::ST_OUT;
                end
            end
            swms_pkg::ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load     = 1'b1;
                    stream_clear = 1'b1;
                    state_next   = swms_pkg::ST_IDLE;
                end
            end
            default: state_next = swms_pkg::ST_IDLE;
        endcase
    end

    // control state: config, set bookkeeping, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg   <= LW'(1);
            var_mode_reg  <= 1'b0;
            pos_reg       <= '0;
            seen_reg      <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            best_key_reg  <= '0;
            best_csum_reg <= '0;
            have_best_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_acc && (cfg_index == swms_pkg::REG_WINDOW_LEN ||
                            cfg_index == swms_pkg::REG_VARIANCE_MODE))
            begin
                case (cfg_index)
                    swms_pkg::REG_WINDOW_LEN:    win_len_reg  <= cfg_data;
                    swms_pkg::REG_VARIANCE_MODE: var_mode_reg <= cfg_data[0];
                    default:                     win_len_reg  <= win_len_reg;
                endcase
                pos_reg       <= '0;
                seen_reg      <= '0;
                s1_reg        <= '0;
                s2_reg        <= '0;
                best_key_reg  <= '0;
                best_csum_reg <= '0;
                have_best_reg <= 1'b0;
            end
            else if (stream_clear)
            begin
                pos_reg       <= '0;
                seen_reg      <= '0;
                s1_reg        <= '0;
                s2_reg        <= '0;
                best_key_reg  <= '0;
                best_csum_reg <= '0;
                have_best_reg <= 1'b0;
            end
            else
            begin
                if (in_acc)
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
                if (state_reg == swms_pkg::ST_READ)
                begin
                    // advance the running sum, drop the oldest sample
                    s1_reg <= s1_reg + {{(UW-SW){v_reg[SW-1]}}, v_reg}
                                     - {{(UW-SW){old_sel[SW-1]}}, old_sel};
                    if (!full_reg)
                    begin
                        seen_reg <= seen_reg + 1'b1;
                    end
                end
                if (state_reg == swms_pkg::ST_SQ)
                begin
                    s2_reg <= s2_reg + SQW'(sqv_reg) - SQW'(sqo_reg);
                end
                if (state_reg == swms_pkg::ST_CMP && win_full)
                begin
                    // strict compare keeps the first minimum on ties
                    if (!have_best_reg || key_w < best_key_reg)
                    begin
                        best_key_reg  <= key_w;
                        best_csum_reg <= csum_w;
                        have_best_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            v_reg    <= sample;
            last_reg <= last_sample;
            full_reg <= win_full;
        end
        if (state_reg == swms_pkg::ST_READ)
        begin
            first_reg <= first_sel;
            sqv_reg   <= unsigned'(sqv_w);
            sqo_reg   <= unsigned'(sqo_w);
        end
        if (state_reg == swms_pkg::ST_SQ)
        begin
            diff_reg   <= {v_reg[SW-1], v_reg} - {first_reg[SW-1], first_reg};
            csum_s_reg <= {v_reg[SW-1], v_reg} + {first_reg[SW-1], first_reg};
            m_reg      <= s1_reg[UW-1] ? MW'(-s1_reg) : MW'(s1_reg);
        end
        if (state_reg == swms_pkg::ST_FIN)
        begin
            m_reg <= dmag[MW-1:0];
        end
        if (state_reg == swms_pkg::ST_MUL)
        begin
            p1_reg <= p1_w;
            p2_reg <= mm_w;
        end

        case (state_reg)
            swms_pkg::ST_FIN:
            begin
                res_centre_reg <= '0;
                res_crit_reg   <= '0;
                res_status_reg <= !win_full || !have_best_reg;
            end
            swms_pkg::ST_SQR:
            begin
                res_centre_reg <= best_csum_reg[SW:1];
                res_crit_reg   <= crit_sh[CW-1:0];
            end
            swms_pkg::ST_DIVK:
            begin
                if (div_stat.done)
                begin
                    res_crit_reg <= div_q[CW-1:0];
                end
            end
            swms_pkg::ST_DIVC:
            begin
                // floor toward minus infinity for a negative sum
                if (div_stat.done)
                begin
                    res_centre_reg <= csum_neg ? signed'(-cq) : signed'(cq);
                end
            end
            default:
            begin
                res_status_reg <= res_status_reg;
            end
        endcase

        if (out_load)
        begin
            out_centre_reg <= res_centre_reg;
            out_crit_reg   <= res_crit_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign centre    = out_centre_reg;
    assign criterion = out_crit_reg;
    assign status    = out_status_reg;

    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == swms_pkg::ST_IDLE |-> seen_reg <= len_eff)
        else $error("sample count above window length");

    a_best_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        have_best_reg |-> seen_reg >= len_eff)
        else $error("best window recorded before a full window");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == swms_pkg::ST_DIVK || state_reg == swms_pkg::ST_DIVC))
        else $error("divider finished outside a division step");

    a_short_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> centre == '0 && criterion == '0)
        else $error("short set result carries nonzero fields");

endmodule

// ----- rtl/swms_ram.sv -----
// ----------------------------------------------------------------------------
// swms_ram: sample delay memory
// One write port and two read ports, read data registered.
// A read of the entry written at the same edge returns the old contents.
// ----------------------------------------------------------------------------
module swms_ram (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [swms_pkg::ADDR_W-1:0]          wr_addr,
    input  logic signed [swms_pkg::SAMPLE_W-1:0] wr_data,
    input  logic [swms_pkg::ADDR_W-1:0]          rd_addr_a,
    input  logic [swms_pkg::ADDR_W-1:0]          rd_addr_b,
    output logic signed [swms_pkg::SAMPLE_W-1:0] rd_data_a,
    output logic signed [swms_pkg::SAMPLE_W-1:0] rd_data_b
);

    logic signed [swms_pkg::SAMPLE_W-1:0] mem [swms_pkg::WINDOW_MAX];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ----- rtl/swms_div.sv -----
// ----------------------------------------------------------------------------
// swms_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, by a window length divisor.
// Done pulses once the last step is taken; quotient stays until next start.
// ----------------------------------------------------------------------------
module swms_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [swms_pkg::DIV_W-1:0]       dividend,
    input  logic [swms_pkg::LEN_W-1:0]       divisor,
    output logic [swms_pkg::DIV_W-1:0]       quotient,
    output swms_pkg::div_stat_t              stat
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [swms_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [swms_pkg::DIV_W-1:0]         work_reg;
    logic [swms_pkg::LEN_W-1:0]         rem_reg;
    logic [swms_pkg::LEN_W-1:0]         dsr_reg;

    logic [swms_pkg::LEN_W:0]           rem_sh;
    logic                               ge;
    logic [swms_pkg::LEN_W:0]           rem_sub;
    logic [swms_pkg::LEN_W-1:0]         rem_next;

    // shift in the next dividend bit, subtract when it fits
    assign rem_sh   = {rem_reg, work_reg[swms_pkg::DIV_W-1]};
    assign ge       = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub  = rem_sh - {1'b0, dsr_reg};
    assign rem_next = ge ? rem_sub[swms_pkg::LEN_W-1:0] : rem_sh[swms_pkg::LEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= swms_pkg::DIV_CNT_W'(swms_pkg::DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == swms_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[swms_pkg::DIV_W-2:0], ge};
            rem_reg  <= rem_next;
        end
    end

    assign quotient    = work_reg;
    assign stat.done   = done_reg;
    assign stat.rem_nz = rem_reg != '0;

endmodule
